### rtl/frame_layout_remapper_defines.svh
// Assertion macros shared by the frame layout remapper RTL.
// Every macro expects clk and rst_n in scope; no other dependencies.
`ifndef FRAME_LAYOUT_REMAPPER_DEFINES_SVH
`define FRAME_LAYOUT_REMAPPER_DEFINES_SVH

// same-cycle implication
`define FLM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame_layout_remapper: assertion failed");

// next-cycle implication
`define FLM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame_layout_remapper: assertion failed");

`endif

### rtl/flm_pkg.sv
// Shared types and constants for the frame layout remapper.
// No dependencies; used by every module under rtl.
package flm_pkg;

  localparam int WORD_W          = 32;
  localparam int DEST_W          = 11;
  localparam int MAX_FRAME_WORDS = 2048;
  // source position only needs to exceed every threshold it is compared against
  localparam int POS_W           = 18;
  localparam int SUM_W           = 18;
  localparam int RXC_W           = 13;
  localparam int RXL_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOGICAL_MODE  = 3'd0,
    CFG_CARD_COUNT    = 3'd1,
    CFG_FIRST_CARD    = 3'd2,
    CFG_ROW_COUNT     = 3'd3,
    CFG_COLS_PER_CARD = 3'd4,
    CFG_LOGICAL_COLS  = 3'd5,
    CFG_HEADER_WORDS  = 3'd6,
    CFG_TAIL_WORDS    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic [DEST_W-1:0] dest_index;
    logic [WORD_W-1:0] out_word;
    logic              write_valid;
    logic              stop_seen;
    logic              frame_done;
  } out_item_t;

  typedef struct packed {
    logic             logical_mode;
    logic [3:0]       card_count;
    logic [2:0]       first_card;
    logic [6:0]       row_count;
    logic [5:0]       cols_per_card;
    logic [8:0]       logical_cols;
    logic [5:0]       header_words;
    logic [5:0]       tail_words;
    logic [RXC_W-1:0] rows_x_cols;
    logic [RXL_W-1:0] rows_x_lcols;
  } cfg_t;

endpackage

### rtl/flm_cfg.sv
// Configuration register bank for the frame layout remapper.
// Depends on flm_pkg; also holds the row products used by the tail logic.
module flm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [flm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output flm_pkg::cfg_t                   cfg
);

  flm_pkg::cfg_t cfg_r;
  flm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (flm_pkg::cfg_idx_t'(cfg_index))
        flm_pkg::CFG_LOGICAL_MODE:  cfg_nxt.logical_mode  = cfg_wdata[0];
        flm_pkg::CFG_CARD_COUNT:    cfg_nxt.card_count    = cfg_wdata[3:0];
        flm_pkg::CFG_FIRST_CARD:    cfg_nxt.first_card    = cfg_wdata[2:0];
        flm_pkg::CFG_ROW_COUNT:     cfg_nxt.row_count     = cfg_wdata[6:0];
        flm_pkg::CFG_COLS_PER_CARD: cfg_nxt.cols_per_card = cfg_wdata[5:0];
        flm_pkg::CFG_LOGICAL_COLS:  cfg_nxt.logical_cols  = cfg_wdata[8:0];
        flm_pkg::CFG_HEADER_WORDS:  cfg_nxt.header_words  = cfg_wdata[5:0];
        flm_pkg::CFG_TAIL_WORDS:    cfg_nxt.tail_words    = cfg_wdata[5:0];
        default: ;
      endcase
    end
    cfg_nxt.rows_x_cols  = flm_pkg::RXC_W'(cfg_nxt.row_count) *
                           flm_pkg::RXC_W'(cfg_nxt.cols_per_card);
    cfg_nxt.rows_x_lcols = flm_pkg::RXL_W'(cfg_nxt.row_count) *
                           flm_pkg::RXL_W'(cfg_nxt.logical_cols);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.logical_mode  <= 1'b0;
      cfg_r.card_count    <= 4'd1;
      cfg_r.first_card    <= 3'd0;
      cfg_r.row_count     <= 7'd33;
      cfg_r.cols_per_card <= 6'd8;
      cfg_r.logical_cols  <= 9'd32;
      cfg_r.header_words  <= 6'd43;
      cfg_r.tail_words    <= 6'd1;
      cfg_r.rows_x_cols   <= flm_pkg::RXC_W'(264);
      cfg_r.rows_x_lcols  <= flm_pkg::RXL_W'(1056);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/flm_map.sv
// Position counters and destination index logic for one frame word.
// Depends on flm_pkg and frame_layout_remapper_defines.svh.
`include "frame_layout_remapper_defines.svh"

module flm_map (
  input  logic               clk,
  input  logic               rst_n,
  input  flm_pkg::cfg_t      cfg,
  input  logic               step,
  input  flm_pkg::in_item_t  item,
  output flm_pkg::out_item_t res
);

  logic [flm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]                card_r, card_nxt;
  logic [6:0]                row_r, row_nxt;
  logic [5:0]                col_r, col_nxt;
  logic                      stop_r, stop_nxt;

  logic                      in_data;
  logic [4:0]                card_pos;
  logic [flm_pkg::SUM_W-1:0] dest_data;
  logic [flm_pkg::SUM_W-1:0] data_len;
  logic [flm_pkg::SUM_W-1:0] tail_start;
  logic [flm_pkg::SUM_W-1:0] tail_off;
  logic [flm_pkg::SUM_W-1:0] dest_tail;
  logic                      in_tail;
  logic [flm_pkg::SUM_W-1:0] dest;
  logic                      valid;
  logic                      in_store;
  logic [6:0]                col_inc;
  logic [6:0]                row_inc;

  assign stop_nxt = (pos_r == '0) ? item.word[0] : stop_r;

  assign in_data = (cfg.card_count != '0) && (cfg.row_count != '0) &&
                   (cfg.cols_per_card != '0) && (card_r < cfg.card_count);

  assign card_pos  = 5'(cfg.first_card) + 5'(card_r);
  assign dest_data = flm_pkg::SUM_W'(cfg.header_words)
                   + flm_pkg::SUM_W'(11'(cfg.cols_per_card) * 11'(card_pos))
                   + flm_pkg::SUM_W'(16'(row_r) * 16'(cfg.logical_cols))
                   + flm_pkg::SUM_W'(col_r);

  assign data_len   = flm_pkg::SUM_W'(cfg.rows_x_cols) * flm_pkg::SUM_W'(cfg.card_count);
  assign tail_start = flm_pkg::SUM_W'(cfg.header_words) + data_len;
  assign tail_off   = pos_r - tail_start;
  assign in_tail    = (pos_r >= tail_start) && (tail_off < flm_pkg::SUM_W'(cfg.tail_words));
  assign dest_tail  = flm_pkg::SUM_W'(cfg.header_words)
                    + flm_pkg::SUM_W'(cfg.rows_x_lcols) + tail_off;

  always_comb begin
    dest  = '0;
    valid = 1'b0;
    if (!cfg.logical_mode || (pos_r < flm_pkg::POS_W'(cfg.header_words))) begin
      dest  = pos_r;
      valid = 1'b1;
    end else if (in_data) begin
      dest  = dest_data;
      valid = 1'b1;
    end else if (in_tail) begin
      dest  = dest_tail;
      valid = 1'b1;
    end
  end

  assign in_store = (dest < flm_pkg::SUM_W'(flm_pkg::MAX_FRAME_WORDS));

  always_comb begin
    res.write_valid = valid && in_store;
    res.dest_index  = res.write_valid ? dest[flm_pkg::DEST_W-1:0] : '0;
    res.out_word    = item.word;
    res.stop_seen   = stop_nxt;
    res.frame_done  = item.frame_end;
  end

  assign col_inc = 7'(col_r) + 7'd1;
  assign row_inc = row_r + 7'd1;

  always_comb begin
    card_nxt = card_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    pos_nxt  = (&pos_r) ? pos_r : pos_r + 1'b1;
    if (cfg.logical_mode && (pos_r >= flm_pkg::POS_W'(cfg.header_words)) && in_data) begin
      col_nxt = col_inc[5:0];
      if (col_inc >= 7'(cfg.cols_per_card)) begin
        col_nxt = '0;
        row_nxt = row_inc;
        if (row_inc >= cfg.row_count) begin
          row_nxt  = '0;
          card_nxt = card_r + 4'd1;
        end
      end
    end
    if (item.frame_end) begin
      pos_nxt  = '0;
      card_nxt = '0;
      row_nxt  = '0;
      col_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      card_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
      stop_r <= 1'b0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      card_r <= card_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      stop_r <= stop_nxt;
    end
  end

  `FLM_ASSERT_NXT(a_frame_end_clears, step && item.frame_end, pos_r == '0 && card_r == '0 && row_r == '0 && col_r == '0)
  `FLM_ASSERT_NXT(a_idle_holds, !step, $stable(pos_r) && $stable(stop_r) && $stable(card_r))
  `FLM_ASSERT_NXT(a_stop_capture, step && pos_r == '0, stop_r == $past(item.word[0]))

endmodule

### rtl/frame_layout_remapper.sv
// Top level of the frame layout remapper: input register, mapping logic, result register.
// Depends on flm_pkg, flm_cfg, flm_map and frame_layout_remapper_defines.svh.
//
//   channel   ports                              direction
//   input     in_valid, in_stall, in_data        frame words in
//   result    out_valid, out_stall, out_data     frame writes out
//   config    cfg_we, cfg_index, cfg_wdata       register writes in
//
// One item per cycle sustained while out_stall is low.
// The mapping sits between the input register and the result register.
// Synchronous active-low reset empties both registers and zeroes the counters.
// out_stall backs up through the result register to in_stall in the same cycle.
`include "frame_layout_remapper_defines.svh"

module frame_layout_remapper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  flm_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output flm_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [flm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  flm_pkg::cfg_t      cfg;
  logic               a_valid_r;
  flm_pkg::in_item_t  a_data_r;
  logic               out_valid_r;
  flm_pkg::out_item_t out_data_r;
  flm_pkg::out_item_t res;
  logic               a_adv;

  flm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  flm_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (a_adv),
    .item  (a_data_r),
    .res   (res)
  );

  assign a_adv    = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        a_valid_r <= in_valid;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_data_r <= in_data;
    end
    if (a_adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FLM_ASSERT_IMP(a_stall_only_when_full, in_stall, a_valid_r && out_valid_r)
  `FLM_ASSERT_NXT(a_advance_fills_result, a_adv, out_valid_r)
  `FLM_ASSERT_NXT(a_stalled_item_held, in_stall, a_valid_r && $stable(a_data_r))

endmodule
